[sv/bzp_pkg.sv]
// Shared constants and types for the cubic Bezier point evaluator.
// No dependencies; imported by bzp_weights, bzp_blend and the top level.
`default_nettype none

package bzp_pkg;

  // control point registers, two per point (x then y)
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  // Bernstein weights per curve parameter
  localparam int NUM_WEIGHTS = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CTRL0_X = 3'd0,
    REG_CTRL0_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_CTRL3_X = 3'd6,
    REG_CTRL3_Y = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

[sv/bzp_weights.sv]
// Three-stage pipeline that turns the curve parameter t into the four
// Bernstein weights. Depends on bzp_pkg.
`default_nettype none

module bzp_weights import bzp_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [T_FRAC_BITS:0]   in_param_t,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [T_FRAC_BITS:0]   out_k [NUM_WEIGHTS]
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = 2 * TW;
  localparam logic [TW-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic          va_r, vb_r, vc_r;
  logic          en_a, en_b, en_c;

  // stage A: clamp, 1 - t
  logic [TW-1:0] t_a_nxt;
  logic [TW-1:0] t_a_r, mt_a_r;
  // stage B: squares
  logic [PW-1:0] mt_sq, t_sq;
  logic [TW-1:0] t_b_r, mt_b_r, mt2_b_r, t2_b_r;
  // stage C: weights
  logic [PW-1:0] p1, p2, p3, p4;
  logic [PW+1:0] p2x3, p3x3;
  logic [TW-1:0] k1_r, k2_r, k3_r, k4_r;

  assign en_c     = !vc_r || out_ready;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  assign t_a_nxt = (in_param_t > ONE) ? ONE : in_param_t;

  always_ff @(posedge clk) begin
    if (en_a) begin
      t_a_r  <= t_a_nxt;
      mt_a_r <= ONE - t_a_nxt;
    end
  end

  assign mt_sq = mt_a_r * mt_a_r;
  assign t_sq  = t_a_r * t_a_r;

  always_ff @(posedge clk) begin
    if (en_b) begin
      t_b_r   <= t_a_r;
      mt_b_r  <= mt_a_r;
      mt2_b_r <= mt_sq[T_FRAC_BITS+TW-1:T_FRAC_BITS];
      t2_b_r  <= t_sq[T_FRAC_BITS+TW-1:T_FRAC_BITS];
    end
  end

  assign p1   = mt2_b_r * mt_b_r;
  assign p2   = mt2_b_r * t_b_r;
  assign p3   = t2_b_r * mt_b_r;
  assign p4   = t2_b_r * t_b_r;
  // times three as x + 2x
  assign p2x3 = (PW+2)'(p2) + ((PW+2)'(p2) << 1);
  assign p3x3 = (PW+2)'(p3) + ((PW+2)'(p3) << 1);

  always_ff @(posedge clk) begin
    if (en_c) begin
      k1_r <= p1[T_FRAC_BITS+TW-1:T_FRAC_BITS];
      k2_r <= p2x3[T_FRAC_BITS+TW-1:T_FRAC_BITS];
      k3_r <= p3x3[T_FRAC_BITS+TW-1:T_FRAC_BITS];
      k4_r <= p4[T_FRAC_BITS+TW-1:T_FRAC_BITS];
    end
  end

  assign out_valid = vc_r;
  assign out_k[0]  = k1_r;
  assign out_k[1]  = k2_r;
  assign out_k[2]  = k3_r;
  assign out_k[3]  = k4_r;

  // t and 1-t always sum to exactly one
  a_mt_complement: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> ((TW+1)'(t_a_r) + (TW+1)'(mt_a_r)) == (TW+1)'(ONE))
    else $error("stage A: t + (1-t) != 1");

  // t = 0 squares exactly
  a_square_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && t_b_r == '0) |-> (mt2_b_r == ONE && t2_b_r == '0))
    else $error("stage B: wrong squares at t = 0");

  // truncation can only lose weight, never add it
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |-> ((TW+2)'(k1_r) + (TW+2)'(k2_r) + (TW+2)'(k3_r) + (TW+2)'(k4_r))
             <= (TW+2)'(ONE))
    else $error("stage C: weights sum above one");

endmodule

`default_nettype wire

[sv/bzp_blend.sv]
// Three-stage pipeline that forms the weighted sum of the control points
// for x and y, floors and saturates it. Depends on bzp_pkg.
`default_nettype none

module bzp_blend import bzp_pkg::*; #(
  parameter int COORD_BITS  = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic        [T_FRAC_BITS:0]   in_k [NUM_WEIGHTS],
  input  wire logic        [COORD_BITS-1:0]  ctrl [NUM_REGS],
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [COORD_BITS-1:0]  out_point_x,
  output logic signed      [COORD_BITS-1:0]  out_point_y
);

  localparam int TW    = T_FRAC_BITS + 1;
  localparam int LO_W  = COORD_BITS / 2;
  localparam int HI_W  = COORD_BITS - LO_W;
  localparam int PL_W  = LO_W + TW;
  localparam int PH_W  = HI_W + TW + 1;
  localparam int ACC_W = COORD_BITS + TW + 2;
  localparam int SH_W  = ACC_W - T_FRAC_BITS;
  localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic vd_r, ve_r, vf_r;
  logic en_d, en_e, en_f;

  // stage D: split partial products, each coordinate as signed hi : unsigned lo
  logic        [PL_W-1:0]       pl_nxt [2][NUM_WEIGHTS];
  logic signed [PH_W-1:0]       ph_nxt [2][NUM_WEIGHTS];
  logic        [PL_W-1:0]       pl_r   [2][NUM_WEIGHTS];
  logic signed [PH_W-1:0]       ph_r   [2][NUM_WEIGHTS];
  // stage E: full products, pair sums
  logic signed [ACC_W-1:0]      term   [2][NUM_WEIGHTS];
  logic signed [ACC_W-1:0]      s01_r  [2];
  logic signed [ACC_W-1:0]      s23_r  [2];
  // stage F: total, floor, saturate
  logic signed [ACC_W-1:0]      total  [2];
  logic        [SH_W-1:0]       shr    [2];
  logic        [COORD_BITS-1:0] pt_nxt [2];
  logic        [COORD_BITS-1:0] pt_r   [2];

  assign en_f     = !vf_r || out_ready;
  assign en_e     = !ve_r || en_f;
  assign en_d     = !vd_r || en_e;
  assign in_ready = en_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (en_d) vd_r <= in_valid;
      if (en_e) ve_r <= vd_r;
      if (en_f) vf_r <= ve_r;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    for (genvar i = 0; i < NUM_WEIGHTS; i++) begin : g_lane
      assign pl_nxt[a][i] = ctrl[2*i+a][LO_W-1:0] * in_k[i];
      assign ph_nxt[a][i] = $signed(ctrl[2*i+a][COORD_BITS-1:LO_W])
                            * $signed({1'b0, in_k[i]});

      always_ff @(posedge clk) begin
        if (en_d) begin
          pl_r[a][i] <= pl_nxt[a][i];
          ph_r[a][i] <= ph_nxt[a][i];
        end
      end

      assign term[a][i] = ($signed(ACC_W'(ph_r[a][i])) <<< LO_W)
                          + $signed(ACC_W'(pl_r[a][i]));
    end

    always_ff @(posedge clk) begin
      if (en_e) begin
        s01_r[a] <= term[a][0] + term[a][1];
        s23_r[a] <= term[a][2] + term[a][3];
      end
    end

    assign total[a] = s01_r[a] + s23_r[a];
    // arithmetic drop of the fraction bits = floor
    assign shr[a]   = total[a][ACC_W-1:T_FRAC_BITS];

    always_comb begin
      if ((&shr[a][SH_W-1:COORD_BITS-1]) || !(|shr[a][SH_W-1:COORD_BITS-1])) begin
        pt_nxt[a] = shr[a][COORD_BITS-1:0];
      end else if (shr[a][SH_W-1]) begin
        pt_nxt[a] = SAT_MIN;
      end else begin
        pt_nxt[a] = SAT_MAX;
      end
    end

    always_ff @(posedge clk) begin
      if (en_f) pt_r[a] <= pt_nxt[a];
    end
  end

  assign out_valid   = vf_r;
  assign out_point_x = $signed(pt_r[0]);
  assign out_point_y = $signed(pt_r[1]);

endmodule

`default_nettype wire

[sv/cubic_bezier_point_eval_core.sv]
// Top level of the cubic Bezier point evaluator: control point registers on
// an APB-style port, weight pipeline and blend pipeline. Depends on bzp_pkg,
// bzp_weights and bzp_blend.
`default_nettype none

// Evaluates a 2-D cubic Bezier curve at one parameter t (unsigned Q1.16,
// values above 1.0 clamp to 1.0) per transaction and returns the saturated
// point in the control-point format. One transaction per clock cycle is
// sustained while out_ready stays high; each passes six register stages
// up to and including the output register: three stages of the weight
// pipeline (clamp, squares, Bernstein weights) and three of the blend
// pipeline (split partial products, pair sums, final sum with floor and
// saturation). Every stage carries its own valid bit, so output
// backpressure only stalls stages that are occupied.
// The eight control coordinates sit at byte address 4*i (8*i for coordinates
// wider than 32 bits) in the order ctrl0_x, ctrl0_y .. ctrl3_y. The user must
// ensure they are written only while no transaction is in flight; the block does not enforce it.
module cubic_bezier_point_eval_core import bzp_pkg::*; #(
  parameter int COORD_BITS  = 24,
  parameter int T_FRAC_BITS = 16,
  localparam int DATA_W     = (COORD_BITS > 32) ? 64 : 32,
  localparam int STRIDE_LOG = (COORD_BITS > 32) ? 3 : 2,
  localparam int ADDR_W     = REG_IDX_W + STRIDE_LOG
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic        [ADDR_W-1:0]      paddr,
  input  wire logic        [DATA_W-1:0]      pwdata,
  output logic             [DATA_W-1:0]      prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic        [T_FRAC_BITS:0]   in_param_t,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [COORD_BITS-1:0]  out_point_x,
  output logic signed      [COORD_BITS-1:0]  out_point_y
);

  logic [COORD_BITS-1:0] ctrl_r [NUM_REGS];
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  logic                  w_valid, w_ready;
  logic [T_FRAC_BITS:0]  w_k [NUM_WEIGHTS];

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:STRIDE_LOG];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = DATA_W'(ctrl_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGS; r++) ctrl_r[r] <= '0;
    end else if (cfg_wr) begin
      ctrl_r[reg_idx] <= pwdata[COORD_BITS-1:0];
    end
  end

  bzp_weights #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_weights (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_param_t (in_param_t),
    .out_valid  (w_valid),
    .out_ready  (w_ready),
    .out_k      (w_k)
  );

  bzp_blend #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (w_valid),
    .in_ready    (w_ready),
    .in_k        (w_k),
    .ctrl        (ctrl_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y)
  );

  // input side only stalls when the whole pipe is full behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // a write to the start x register lands
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && reg_idx == REG_CTRL0_X) |=>
      ctrl_r[REG_CTRL0_X] == $past(pwdata[COORD_BITS-1:0]))
    else $error("ctrl0_x write lost");

endmodule

`default_nettype wire
